>>> rtl/iorr_pkg.sv
// Package with the sizes, codes and state type of the in-order response release block.
`default_nettype none

package iorr_pkg;

	// Sizing of the block.
	localparam int CONNECTIONS = 4;
	localparam int WINDOW      = 16;
	localparam int MAX_RESULTS = 16;
	localparam int EFF_WIN     = (WINDOW < MAX_RESULTS) ? WINDOW : MAX_RESULTS;

	// Derived widths.
	localparam int SLOTS  = CONNECTIONS * WINDOW;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CONN_W = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
	localparam int HEAD_W = $clog2(WINDOW);
	localparam int SUM_W  = HEAD_W + 1;
	localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

	// Field widths of the beats.
	localparam int ID_W     = 2;
	localparam int INDEX_W  = 16;
	localparam int HANDLE_W = 32;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_SENT      = 2'd0,
		ST_HELD      = 2'd1,
		ST_DROP_CONN = 2'd2,
		ST_DROP_WIN  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_DRAIN
	} state_t;

endpackage

`default_nettype wire

>>> rtl/in_order_response_release_top.sv
// Top level of the in-order response release block: a per-connection reorder buffer.
`default_nettype none

// Per-connection reorder buffer. Each input beat commits one response for a
// connection; a response whose sequence index is the one the connection
// expects next is sent at once, followed by every held response that follows
// on without a gap, up to sixteen results for one input beat. An early
// response that falls inside the window is held in a slot and reported as
// held; one for a closed connection, or one that is stale or too far ahead,
// is reported and discarded. Every input beat gives at least one result beat,
// and the final one carries tlast. Held handles live in a single synchronous
// memory with one read port and one write port; the slot-full bits, next
// expected indices and head pointers are flip-flops. An input beat is first
// registered, then evaluated, and its first result is emitted; each held
// response that is drained from the memory needs its own memory read.
// A new input beat is taken while the last result beat still waits in the
// output register; evaluation waits while that register holds a beat that
// has not been taken.
module in_order_response_release_top
	import iorr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave side: committed responses.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // [15:0] seq_index, [47:16] payload_handle
	input  wire logic [2:0]  s_tuser,   // [1:0] conn_id, [2] conn_valid
	// Master side: results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [15:0] out_index, [47:16] out_handle
	output logic [3:0]       m_tuser,   // [1:0] out_conn, [3:2] status
	output logic             m_tlast    // last result of the input beat
);

	state_t state_q, state_nx;

	// Registered input beat; it stays put until the beat is finished.
	logic [ID_W-1:0]     conn_s1;
	logic [INDEX_W-1:0]  seq_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic                valid_s1;

	// Per-connection state.
	logic [INDEX_W-1:0] next_q [CONNECTIONS];
	logic [HEAD_W-1:0]  head_q [CONNECTIONS];
	logic [SLOTS-1:0]   full_q;

	// Handle memory and its registered read data.
	logic [HANDLE_W-1:0] mem [SLOTS];
	logic [HANDLE_W-1:0] rdata_s2;

	// Results sent so far for the current input beat.
	logic [CNT_W-1:0] cnt_q;

	// Output register.
	logic                m_valid_q;
	logic [ID_W-1:0]     o_conn_q;
	logic [INDEX_W-1:0]  o_index_q;
	logic [HANDLE_W-1:0] o_handle_q;
	status_t             o_status_q;
	logic                o_last_q;

	// Evaluation of the held beat against its connection.
	logic [CONN_W-1:0]  conn_idx;
	logic               conn_ok;
	logic [INDEX_W-1:0] nexp;
	logic [INDEX_W-1:0] delta;
	logic               in_win;
	logic [HEAD_W-1:0]  hd;
	logic [HEAD_W-1:0]  hd_inc;
	logic [SUM_W-1:0]   sum;
	logic [HEAD_W-1:0]  slot_pos;
	logic [SLOT_W-1:0]  base;
	logic [SLOT_W-1:0]  addr_cur;
	logic [SLOT_W-1:0]  addr_inc;
	logic [SLOT_W-1:0]  addr_hold;

	// Control decided in the output block.
	logic                can_emit;
	logic                emit;
	logic                more;
	logic                advance;
	logic                cnt_load;
	logic                mem_we;
	logic                mem_re;
	logic                full_clr;
	logic [INDEX_W-1:0]  e_index;
	logic [HANDLE_W-1:0] e_handle;
	status_t             e_status;

	assign conn_idx = CONN_W'(conn_s1);
	assign conn_ok  = valid_s1 && (32'(conn_s1) < 32'(CONNECTIONS));
	assign nexp     = next_q[conn_idx];
	assign delta    = seq_s1 - nexp;
	assign in_win   = delta < INDEX_W'(EFF_WIN);
	assign hd       = head_q[conn_idx];
	assign hd_inc   = (hd == HEAD_W'(WINDOW - 1)) ? '0 : hd + 1'b1;

	// The distance is below the window here, so one subtraction wraps the slot.
	assign sum      = {1'b0, hd} + SUM_W'(delta);
	assign slot_pos = (sum >= SUM_W'(WINDOW)) ? HEAD_W'(sum - SUM_W'(WINDOW))
	                                          : HEAD_W'(sum);

	assign base      = SLOT_W'(conn_idx) * SLOT_W'(WINDOW);
	assign addr_cur  = base + SLOT_W'(hd);
	assign addr_inc  = base + SLOT_W'(hd_inc);
	assign addr_hold = base + SLOT_W'(slot_pos);

	assign can_emit = !m_valid_q || m_tready;

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nx = S_EVAL;
				end
			end
			S_EVAL, S_DRAIN: begin
				if (emit) begin
					state_nx = more ? S_DRAIN : S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Outputs and datapath control.
	always_comb begin
		s_tready = 1'b0;
		emit     = 1'b0;
		more     = 1'b0;
		advance  = 1'b0;
		cnt_load = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		full_clr = 1'b0;
		e_index  = seq_s1;
		e_handle = '0;
		e_status = ST_SENT;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
			end
			S_EVAL: begin
				emit = can_emit;
				if (!conn_ok) begin
					e_status = ST_DROP_CONN;
				end else if (!in_win) begin
					e_status = ST_DROP_WIN;
				end else if (delta != '0) begin
					e_status = ST_HELD;
					mem_we   = can_emit;
				end else begin
					// In order: send it, and go on if the following slot is full.
					e_status = ST_SENT;
					e_handle = handle_s1;
					advance  = can_emit;
					cnt_load = can_emit;
					more     = full_q[addr_inc] && (MAX_RESULTS > 1);
					mem_re   = can_emit && more;
				end
			end
			S_DRAIN: begin
				emit     = can_emit;
				e_index  = nexp;
				e_handle = rdata_s2;
				e_status = ST_SENT;
				advance  = can_emit;
				full_clr = can_emit;
				more     = full_q[addr_inc] && (32'(cnt_q) + 1 < MAX_RESULTS);
				mem_re   = can_emit && more;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
			full_q    <= '0;
			cnt_q     <= '0;
			for (int i = 0; i < CONNECTIONS; i++) begin
				next_q[i] <= '0;
				head_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (mem_we) begin
				full_q[addr_hold] <= 1'b1;
			end
			if (full_clr) begin
				full_q[addr_cur] <= 1'b0;
			end
			if (advance) begin
				next_q[conn_idx] <= nexp + 1'b1;
				head_q[conn_idx] <= hd_inc;
			end
			if (cnt_load) begin
				cnt_q <= CNT_W'(1);
			end else if (advance) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Input beat and result payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			conn_s1   <= s_tuser[1:0];
			valid_s1  <= s_tuser[2];
			seq_s1    <= s_tdata[15:0];
			handle_s1 <= s_tdata[47:16];
		end
		if (emit) begin
			o_conn_q   <= conn_s1;
			o_index_q  <= e_index;
			o_handle_q <= e_handle;
			o_status_q <= e_status;
			o_last_q   <= !more;
		end
	end

	// Handle memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_hold] <= handle_s1;
		end
		if (mem_re) begin
			rdata_s2 <= mem[addr_inc];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {o_handle_q, o_index_q};
	assign m_tuser  = {o_status_q, o_conn_q};
	assign m_tlast  = o_last_q;

endmodule

`default_nettype wire
